[rtl/lisr_pkg.sv]
// Shared constants for the linear interpolation stereo resampler.
`timescale 1ns / 1ps

package lisr_pkg;

    // Default parameter values
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MAX_OUTPUTS_DEF = 16;

    // Configuration register widths and port shape
    localparam int STEP_W     = 24;
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATIO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MONO       = 2'd2;

    // Configuration reset values
    localparam logic [STEP_W-1:0] STEP_RESET = 24'd65536;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

    // Source position, unsigned Q9.16
    localparam int POS_W  = 25;
    localparam int FRAC_W = 16;
    localparam logic [POS_W-1:0] POS_ONE = 25'h0010000;

    // Second operand of the shared multiplier: a zero-extended 16-bit value
    localparam int MUL_B_W = 17;

    // Final scaling: shift right by 30 with round half up
    localparam int RND_SHIFT = 30;

endpackage

[rtl/linear_interp_stereo_resampler_unit.sv]
// Top level of the linear interpolation stereo resampler.
// A source frame is accepted only in the idle state; each result then runs the left and
// the right channel in turn through one shared multiplier, and the pair waits in the
// emit step until the output register can take it. No new frame is taken before the last
// result of the current one is handed on. Reset: configuration returns to its defaults,
// history frame and position clear, no clearing pass is needed.
`timescale 1ns / 1ps

module linear_interp_stereo_resampler_unit #(
    parameter int SAMPLE_BITS           = lisr_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_OUTPUTS_PER_FRAME = lisr_pkg::MAX_OUTPUTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,

    // Configuration write port
    input  logic                               cfg_wr_en,
    input  logic [lisr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lisr_pkg::CFG_DATA_W-1:0]    cfg_data,

    // Source frame requests
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [SAMPLE_BITS-1:0]      left_in,
    input  logic signed [SAMPLE_BITS-1:0]      right_in,
    input  logic                               restart,

    // Result requests
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [SAMPLE_BITS-1:0]      left_out,
    output logic signed [SAMPLE_BITS-1:0]      right_out,
    output logic                               last_of_run
);
    import lisr_pkg::*;

    // Multiplier operand A covers the sample difference, the high half of the
    // interpolated value and the zero-extended low half.
    localparam int A_W   = (SAMPLE_BITS + 2 > MUL_B_W) ? SAMPLE_BITS + 2 : MUL_B_W;
    localparam int P_W   = A_W + MUL_B_W;
    localparam int LIN_W = SAMPLE_BITS + 18;
    localparam int ACC_W = SAMPLE_BITS + 35;
    localparam int CNT_W = $clog2(MAX_OUTPUTS_PER_FRAME + 1);

    typedef enum logic [3:0] {
        ST_IDLE,   // wait for a source frame
        ST_CHECK,  // decide whether this frame yields any result
        ST_DIFF,   // multiply (cur - prev) by the position fraction
        ST_LIN,    // add prev * 2^16 to get the interpolated value
        ST_LO,     // multiply low half of interpolated value by gain
        ST_HI,     // multiply high half by gain, park low product
        ST_ACC,    // combine both products and the rounding bias
        ST_SAT,    // round, saturate, switch channel
        ST_EMIT    // hand the result pair to the output register
    } state_t;

    // Control state
    state_t                   state_reg, state_next;
    logic                     ch_reg, ch_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [POS_W-1:0]         position_reg, position_next;
    logic signed [SAMPLE_BITS-1:0] prev_l_reg, prev_l_next;
    logic signed [SAMPLE_BITS-1:0] prev_r_reg, prev_r_next;

    // Configuration
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [GAIN_W-1:0]        gain_reg, gain_next;
    logic                     mono_reg, mono_next;

    // Output register
    logic                     out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_l_reg, out_l_next;
    logic signed [SAMPLE_BITS-1:0] out_r_reg, out_r_next;
    logic                     out_last_reg, out_last_next;

    // Datapath payload
    logic signed [SAMPLE_BITS-1:0] cur_l_reg, cur_r_reg;
    logic signed [SAMPLE_BITS-1:0] res_l_reg, res_r_reg;
    logic signed [LIN_W-1:0]  lin_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    // Combinational helpers
    logic                     in_fire;
    logic                     out_load;
    logic [POS_W-1:0]         pos_adv;
    logic                     pos_ge_one;
    logic                     adv_ge_one;
    logic                     last_res;
    logic signed [SAMPLE_BITS-1:0] sel_prev, sel_cur;
    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [SAMPLE_BITS+1:0] lin_hi;
    logic                     mul_en;
    logic signed [A_W-1:0]    mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [P_W-1:0]    prod_reg;
    logic signed [SAMPLE_BITS-1:0] sat_sample;

    assign in_ready    = (state_reg == ST_IDLE);
    assign in_fire     = in_valid & in_ready;

    // In the emit step, load the output register whenever it is empty or being drained
    assign out_load    = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    assign out_valid   = out_valid_reg;
    assign left_out    = out_l_reg;
    assign right_out   = out_r_reg;
    assign last_of_run = out_last_reg;

    // Position after this result; wraps at 25 bits
    assign pos_adv    = position_reg + POS_W'(step_reg);
    assign pos_ge_one = |position_reg[POS_W-1:FRAC_W];
    assign adv_ge_one = |pos_adv[POS_W-1:FRAC_W];

    // The run ends when the position reaches one or the per-frame cap is hit
    assign last_res = adv_ge_one ||
                      (cnt_reg == CNT_W'(MAX_OUTPUTS_PER_FRAME - 1));

    // Channel select for the shared datapath
    assign sel_prev = ch_reg ? prev_r_reg : prev_l_reg;
    assign sel_cur  = ch_reg ? cur_r_reg  : cur_l_reg;
    assign diff     = (SAMPLE_BITS+1)'(sel_cur) - (SAMPLE_BITS+1)'(sel_prev);
    assign lin_hi   = lin_reg[LIN_W-1:FRAC_W];

    // Operand steering for the shared multiplier.
    // lin * gain is split as lin_hi * gain * 2^16 + lin_lo * gain so that
    // one narrow multiplier serves all three products.
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            ST_DIFF:
            begin
                mul_en = 1'b1;
                mul_a  = A_W'(diff);
                mul_b  = {1'b0, position_reg[FRAC_W-1:0]};
            end
            ST_LO:
            begin
                mul_en = 1'b1;
                mul_a  = {{(A_W-FRAC_W){1'b0}}, lin_reg[FRAC_W-1:0]};
                mul_b  = {1'b0, gain_reg};
            end
            ST_HI:
            begin
                mul_en = 1'b1;
                mul_a  = A_W'(lin_hi);
                mul_b  = {1'b0, gain_reg};
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    lisr_mul #(
        .A_W   (A_W)
    ) u_mul (
        .clk   (clk),
        .en    (mul_en),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (prod_reg)
    );

    lisr_sat #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_sat (
        .acc    (acc_reg),
        .sample (sat_sample)
    );

    // Datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            // Mono: right copies left
            cur_l_reg <= left_in;
            cur_r_reg <= mono_reg ? left_in : right_in;
        end
        if (state_reg == ST_LIN)
        begin
            lin_reg <= (LIN_W'(sel_prev) <<< FRAC_W) + LIN_W'(prod_reg);
        end
        if (state_reg == ST_HI)
        begin
            // prod_reg holds lin_lo * gain here
            acc_reg <= ACC_W'(prod_reg);
        end
        if (state_reg == ST_ACC)
        begin
            // prod_reg holds lin_hi * gain here; add half an LSB for rounding
            acc_reg <= acc_reg + (ACC_W'(prod_reg) <<< FRAC_W)
                       + (ACC_W'(1) << (RND_SHIFT - 1));
        end
        if ((state_reg == ST_SAT) && !ch_reg)
        begin
            res_l_reg <= sat_sample;
        end
        if ((state_reg == ST_SAT) && ch_reg)
        begin
            res_r_reg <= sat_sample;
        end
    end

    // Sequencer and control next-state logic
    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        cnt_next       = cnt_reg;
        position_next  = position_reg;
        prev_l_next    = prev_l_reg;
        prev_r_next    = prev_r_reg;
        step_next      = step_reg;
        gain_next      = gain_reg;
        mono_next      = mono_reg;
        out_l_next     = out_l_reg;
        out_r_next     = out_r_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg;

        // Configuration writes; unknown indexes are dropped
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_STEP_RATIO: step_next = cfg_data[STEP_W-1:0];
                CFG_GAIN:       gain_next = cfg_data[GAIN_W-1:0];
                CFG_MONO:       mono_next = cfg_data[0];
                default:        ;
            endcase
        end

        // Output register: hold until taken
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cnt_next   = '0;
                    ch_next    = 1'b0;
                    state_next = ST_CHECK;
                    if (restart)
                    begin
                        // Clear history before this frame is used
                        prev_l_next   = '0;
                        prev_r_next   = '0;
                        position_next = '0;
                    end
                end
            end
            ST_CHECK:
            begin
                if (!pos_ge_one)
                begin
                    state_next = ST_DIFF;
                end
                else
                begin
                    // No result for this frame: drop one source period and store it
                    position_next = position_reg - POS_ONE;
                    prev_l_next   = cur_l_reg;
                    prev_r_next   = cur_r_reg;
                    state_next    = ST_IDLE;
                end
            end
            ST_DIFF: state_next = ST_LIN;
            ST_LIN:  state_next = ST_LO;
            ST_LO:   state_next = ST_HI;
            ST_HI:   state_next = ST_ACC;
            ST_ACC:  state_next = ST_SAT;
            ST_SAT:
            begin
                if (!ch_reg)
                begin
                    ch_next    = 1'b1;
                    state_next = ST_DIFF;
                end
                else
                begin
                    ch_next    = 1'b0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    out_l_next    = res_l_reg;
                    out_r_next    = res_r_reg;
                    out_last_next = last_res;
                    cnt_next      = cnt_reg + CNT_W'(1);
                    if (last_res)
                    begin
                        // End of run: drop one period, floor at zero, store frame
                        position_next = adv_ge_one ? (pos_adv - POS_ONE) : '0;
                        prev_l_next   = cur_l_reg;
                        prev_r_next   = cur_r_reg;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        position_next = pos_adv;
                        state_next    = ST_DIFF;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, history, configuration and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= 1'b0;
            cnt_reg       <= '0;
            position_reg  <= '0;
            prev_l_reg    <= '0;
            prev_r_reg    <= '0;
            step_reg      <= STEP_RESET;
            gain_reg      <= GAIN_RESET;
            mono_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_l_reg     <= '0;
            out_r_reg     <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            cnt_reg       <= cnt_next;
            position_reg  <= position_next;
            prev_l_reg    <= prev_l_next;
            prev_r_reg    <= prev_r_next;
            step_reg      <= step_next;
            gain_reg      <= gain_next;
            mono_reg      <= mono_next;
            out_valid_reg <= out_valid_next;
            out_l_reg     <= out_l_next;
            out_r_reg     <= out_r_next;
            out_last_reg  <= out_last_next;
        end
    end

`ifndef ASSERT_OFF
    // Result count never passes the per-frame cap
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_OUTPUTS_PER_FRAME))
        else $error("result count exceeds per-frame cap");

    // A restart request clears position and history
    a_restart_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && restart) |=> (position_reg == '0) && (prev_l_reg == '0)
                                 && (prev_r_reg == '0))
        else $error("restart did not clear history");

    // A new result only appears out of the emit step
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result valid raised outside emit");

    // The last result of a run frees the input side
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_res) |=> in_ready && out_last_reg)
        else $error("input not ready after last result");
`endif

endmodule

[rtl/lisr_mul.sv]
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module lisr_mul #(
    parameter int A_W = 18
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [A_W-1:0]                 a,
    input  logic signed [lisr_pkg::MUL_B_W-1:0]   b,
    output logic signed [A_W+lisr_pkg::MUL_B_W-1:0] p_reg
);
    import lisr_pkg::*;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= a * b;
        end
    end

endmodule

[rtl/lisr_sat.sv]
// Rounded right shift and saturation of the scaled accumulator to one sample.
`timescale 1ns / 1ps

module lisr_sat #(
    parameter int SAMPLE_BITS = lisr_pkg::SAMPLE_BITS_DEF
) (
    input  logic signed [SAMPLE_BITS+34:0]  acc,
    output logic signed [SAMPLE_BITS-1:0]   sample
);
    import lisr_pkg::*;

    localparam int ACC_W = SAMPLE_BITS + 35;
    localparam int Q_W   = ACC_W - RND_SHIFT;

    logic signed [Q_W-1:0] q;
    logic                  fits;

    // Bias is already in acc, so dropping the low bits rounds half up
    assign q    = acc[ACC_W-1:RND_SHIFT];
    assign fits = (q[Q_W-1:SAMPLE_BITS-1] == {(Q_W-SAMPLE_BITS+1){q[Q_W-1]}});

    always_comb
    begin
        if (fits)
        begin
            sample = q[SAMPLE_BITS-1:0];
        end
        else if (q[Q_W-1])
        begin
            sample = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            sample = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

endmodule
